// ----- design/bkoff_pkg.sv -----
// Shared types and codes for the reconnect backoff scheduler.
`default_nettype none

package bkoff_pkg;

  // Event codes carried in the opcode field
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_FAIL  = 2'd1;
  localparam logic [1:0] OP_LOGIN = 2'd2;

  // Register indexes, byte address 4*index
  localparam logic [1:0] REG_HB_INTERVAL = 2'd0;
  localparam logic [1:0] REG_FAST_RETRY  = 2'd1;
  localparam logic [1:0] REG_FAST_WINDOW = 2'd2;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic [31:0] random_word;
    logic        draining;
  } in_item_t;

  typedef struct packed {
    logic        scheduled;
    logic [31:0] delay_ms;
    logic        fast_mode;
    logic        unreachable;
  } out_item_t;

  // Programmed registers plus the values derived from the interval
  typedef struct packed {
    logic [11:0] heartbeat_interval_s;
    logic [15:0] fast_retry_ms;
    logic [19:0] fast_window_ms;
    logic [31:0] heartbeat_ms;
    logic [31:0] cap_ms;
    logic [31:0] seed_ms;
  } cfg_t;

endpackage : bkoff_pkg

`default_nettype wire

// ----- design/reconnect_backoff_scheduler.sv -----
// Top level of the reconnect backoff scheduler: event sequencer and state.
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_item_i) takes one start, failure or
//   login event; each event yields exactly one item on the output channel
//   (out_valid_o/out_ready_i, out_item_o), in order.
//   Configuration is written through the APB port (interval, fast retry,
//   fast window at byte addresses 0, 4 and 8); pready is always high.
// Timing:
//   One event is in flight at a time. Start, login, drained or fast-retry
//   events pass through the EVAL and PUSH states to the output register. A failure
//   with a nonzero backoff runs the jitter remainder through a bit-serial
//   divider, one bit per cycle, in the DIV state between EVAL and PUSH.
// Reset:
//   Registers return to interval 10 s, fast retry 50 ms, window 5000 ms;
//   backoff, login flag and window deadline clear to zero.
// Stalls:
//   A finished item waits in the output register while the next event is
//   accepted and processed; the following result holds until it drains.
`default_nettype none

module reconnect_backoff_scheduler #(
  parameter int unsigned BACKOFF_MAX_MS     = 60000,
  parameter int unsigned BACKOFF_INITIAL_MS = 1000
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire bkoff_pkg::in_item_t             in_item_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output bkoff_pkg::out_item_t                 out_item_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bkoff_pkg::AddrWidth-1:0] paddr,
  input  wire logic [bkoff_pkg::DataWidth-1:0] pwdata,
  output logic      [bkoff_pkg::DataWidth-1:0] prdata,
  output logic                                 pready
);
  import bkoff_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_PUSH
  } state_e;

  state_e    state_q;
  cfg_t      cfg;
  in_item_t  item_q;
  out_item_t res_q, out_q, eval_res;
  logic      out_valid_q;
  logic [31:0] backoff_q, deadline_q;
  logic        logged_q;

  logic        is_fail, in_window, fast_hit, div_start, div_done, out_load;
  logic [31:0] deadline_new, diff, backoff_grow;
  logic [32:0] backoff_x2, jitter_sum;
  logic [30:0] divisor, rem;

  bkoff_regs #(
    .BACKOFF_MAX_MS    (BACKOFF_MAX_MS),
    .BACKOFF_INITIAL_MS(BACKOFF_INITIAL_MS)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  always_comb begin
    is_fail      = (item_q.opcode == OP_FAIL) && !item_q.draining;
    in_window    = !logged_q && (cfg.fast_window_ms != '0);
    deadline_new = item_q.now_ms + 32'(cfg.fast_window_ms);
    diff         = deadline_q - item_q.now_ms;
    // an unstarted window always yields a positive distance to its new deadline
    fast_hit     = in_window && ((deadline_q == '0) || ((diff != '0) && !diff[31]));
    backoff_x2   = {backoff_q, 1'b0};
    if (backoff_q < cfg.cap_ms) begin
      backoff_grow = (backoff_x2 > {1'b0, cfg.cap_ms}) ? cfg.cap_ms : backoff_x2[31:0];
    end else begin
      backoff_grow = backoff_q;
    end
    divisor      = {1'b0, backoff_q[31:2]} + 31'd1;
    div_start    = (state_q == ST_EVAL) && is_fail && !fast_hit && (backoff_q != '0);
    jitter_sum   = {1'b0, res_q.delay_ms} + 33'(rem);
    out_load     = (state_q == ST_PUSH) && (!out_valid_q || out_ready_i);
    eval_res     = '0;
    unique case (item_q.opcode)
      OP_LOGIN: begin
        if (!item_q.draining) begin
          eval_res.scheduled = 1'b1;
          eval_res.delay_ms  = cfg.heartbeat_ms;
        end
      end
      OP_FAIL: begin
        if (is_fail) begin
          eval_res.scheduled = 1'b1;
          if (fast_hit) begin
            eval_res.delay_ms  = 32'(cfg.fast_retry_ms);
            eval_res.fast_mode = 1'b1;
          end else begin
            eval_res.delay_ms    = backoff_q;
            eval_res.unreachable = in_window;
          end
        end
      end
      default: ;
    endcase
  end

  bkoff_rem u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(item_q.random_word),
    .divisor_i (divisor),
    .done_o    (div_done),
    .rem_o     (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      backoff_q   <= '0;
      deadline_q  <= '0;
      logged_q    <= 1'b0;
      item_q      <= '0;
      res_q       <= '0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_item_i;
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          res_q   <= eval_res;
          state_q <= div_start ? ST_DIV : ST_PUSH;
          unique case (item_q.opcode)
            OP_START: begin
              backoff_q  <= cfg.seed_ms;
              logged_q   <= 1'b0;
              deadline_q <= '0;
            end
            OP_LOGIN: begin
              backoff_q  <= cfg.seed_ms;
              logged_q   <= 1'b1;
              deadline_q <= '0;
            end
            OP_FAIL: begin
              if (is_fail) begin
                if (fast_hit) begin
                  if (deadline_q == '0) begin
                    deadline_q <= deadline_new;
                  end
                end else begin
                  backoff_q <= backoff_grow;
                end
              end
            end
            default: ;
          endcase
        end
        ST_DIV: begin
          if (div_done) begin
            res_q.delay_ms <= jitter_sum[32] ? '1 : jitter_sum[31:0];
            state_q        <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          // load once the output register is free or draining this cycle
          if (out_load) begin
            out_q   <= res_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !$rose(out_valid_q))
    else $error("result appeared before the event was evaluated");
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV)) else $error("remainder done outside divide state");
  a_idle_unsched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.scheduled || (out_q.delay_ms == '0 && !out_q.fast_mode)))
    else $error("unscheduled result carries a delay");
  a_fast_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.fast_mode) |-> (out_q.scheduled && !out_q.unreachable))
    else $error("fast retry flagged unreachable");
`endif

endmodule : reconnect_backoff_scheduler

`default_nettype wire

// ----- design/bkoff_regs.sv -----
// Configuration registers with APB access and derived interval values.
`default_nettype none

module bkoff_regs #(
  parameter int unsigned BACKOFF_MAX_MS     = 60000,
  parameter int unsigned BACKOFF_INITIAL_MS = 1000
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [bkoff_pkg::AddrWidth-1:0]    paddr,
  input  wire logic [bkoff_pkg::DataWidth-1:0]    pwdata,
  output logic      [bkoff_pkg::DataWidth-1:0]    prdata,
  output logic                                    pready,
  output bkoff_pkg::cfg_t                         cfg_o
);
  import bkoff_pkg::*;

  logic [11:0] hb_q;
  logic [15:0] fr_q;
  logic [19:0] fw_q;
  logic [31:0] hb_ms_q, cap_q, seed_q;
  logic [31:0] hb_ms_d, hb_cap_d, cap_d, seed_d;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[AddrWidth-1:2];

  always_comb begin
    hb_ms_d  = 32'(hb_q) * 32'd1000;
    hb_cap_d = 32'(hb_q) * 32'd10000;
    cap_d    = (hb_cap_d < 32'(BACKOFF_MAX_MS)) ? hb_cap_d : 32'(BACKOFF_MAX_MS);
    seed_d   = (hb_ms_d < 32'(BACKOFF_INITIAL_MS)) ? hb_ms_d : 32'(BACKOFF_INITIAL_MS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_q    <= 12'd10;
      fr_q    <= 16'd50;
      fw_q    <= 20'd5000;
      hb_ms_q <= '0;
      cap_q   <= '0;
      seed_q  <= '0;
    end else begin
      hb_ms_q <= hb_ms_d;
      cap_q   <= cap_d;
      seed_q  <= seed_d;
      if (wr_en) begin
        unique case (reg_idx)
          REG_HB_INTERVAL: hb_q <= pwdata[11:0];
          REG_FAST_RETRY:  fr_q <= pwdata[15:0];
          REG_FAST_WINDOW: fw_q <= pwdata[19:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HB_INTERVAL: prdata = 32'(hb_q);
      REG_FAST_RETRY:  prdata = 32'(fr_q);
      REG_FAST_WINDOW: prdata = 32'(fw_q);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = '{heartbeat_interval_s: hb_q, fast_retry_ms: fr_q, fast_window_ms: fw_q,
                   heartbeat_ms: hb_ms_q, cap_ms: cap_q, seed_ms: seed_q};

endmodule : bkoff_regs

`default_nettype wire

// ----- design/bkoff_rem.sv -----
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`default_nettype none

module bkoff_rem (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [30:0] divisor_i,
  output logic             done_o,
  output logic      [30:0] rem_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] shift_q;
  logic [30:0] rem_q, div_q;
  logic [32:0] trial;

  // Partial remainder with the next dividend bit shifted in, less the divisor
  assign trial = {1'b0, rem_q, shift_q[31]} - {2'b00, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      shift_q <= '0;
      rem_q   <= '0;
      div_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        cnt_q   <= '0;
        shift_q <= dividend_i;
        rem_q   <= '0;
        div_q   <= divisor_i;
      end else if (busy_q) begin
        // keep the trial difference unless it went negative
        rem_q   <= trial[32] ? {rem_q[29:0], shift_q[31]} : trial[30:0];
        shift_q <= {shift_q[30:0], 1'b0};
        cnt_q   <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("remainder unit started while busy");
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 5'd31 && !start_i) |=> done_q)
    else $error("remainder unit missed its done pulse");
  a_done_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < div_q)) else $error("remainder not below divisor");
`endif

endmodule : bkoff_rem

`default_nettype wire
